// ----- rtl/core/label_erosion_3x3_defines.svh -----
// assertion macros shared by the label erosion rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef LABEL_EROSION_3X3_DEFINES_SVH
`define LABEL_EROSION_3X3_DEFINES_SVH

// property checked on every clock edge outside reset
`define LERO_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication: antecedent this cycle, consequent in the cycle after
`define LERO_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lero_pkg.sv -----
// shared types, constants and the erosion function for label_erosion_3x3
// no dependencies
`timescale 1ns / 1ps

package lero_pkg;

    // image geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 12;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_ROI_COL_START   = 3'd2,
        REG_ROI_COL_END     = 3'd3,
        REG_ROI_ROW_START   = 3'd4,
        REG_ROI_ROW_END     = 3'd5,
        REG_TARGET_LABEL    = 3'd6,
        REG_EIGHT_CONNECTED = 3'd7
    } cfg_reg_t;

    // line buffer entry: upper line in the high byte, lower line in the low byte
    typedef logic [2*PIX_W-1:0] lb_word_t;

    // line buffer port controls
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } lb_ctl_t;

    // 3x3 window in raster order, entry 4 is the centre
    typedef logic [8:0][PIX_W-1:0] window_t;

    // position info of the window centre, worked out when the item is taken
    typedef struct packed {
        logic       emit;
        logic       done;
        logic       in_roi;
        logic [2:0] row_ok;   // top, middle, bottom rows inside the image
        logic [2:0] col_ok;   // left, middle, right columns inside the image
    } pos_info_t;

    // roi centre equal to label: last differing in-image neighbour in raster order
    function automatic logic [PIX_W-1:0] erode_px(
        input window_t          win,
        input logic [PIX_W-1:0] label,
        input logic             eight,
        input pos_info_t        info
    );
        logic [PIX_W-1:0] res;
        logic             use_nb;
        res = win[4];
        if (info.in_roi && (win[4] == label)) begin
            for (int k = 0; k < 9; k++) begin
                use_nb = (k != 4) && info.row_ok[k/3] && info.col_ok[k%3];
                if (!eight && (k/3 != 1) && (k%3 != 1)) begin
                    use_nb = 1'b0;
                end
                if (use_nb && (win[k] != label)) begin
                    res = win[k];
                end
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/lero_line_buf.sv -----
// dual line store for label_erosion_3x3: one memory of upper/lower line pairs
// depends on lero_pkg and label_erosion_3x3_defines.svh
`timescale 1ns / 1ps
`include "label_erosion_3x3_defines.svh"

module lero_line_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  lero_pkg::lb_ctl_t ctl,
    input  lero_pkg::lb_word_t wr_data,
    output lero_pkg::lb_word_t rd_data
);
    import lero_pkg::*;

    lb_word_t mem [MAX_WIDTH];
    lb_word_t rd_raw_reg;
    lb_word_t fwd_data_reg;
    logic     fwd_hit_reg;

    // memory array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_raw_reg <= mem[ctl.rd_addr];
        end
    end

    // bypass a write landing on the address read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            fwd_hit_reg <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_raw_reg;

    `LERO_ASSERT_NEXT(a_fwd_same_addr,
        ctl.rd_en && ctl.wr_en && (ctl.rd_addr == ctl.wr_addr),
        rd_data === $past(wr_data), "read after same-address write returned stale data")

endmodule

// ----- rtl/core/label_erosion_3x3.sv -----
// top level of the streaming 3x3 label erosion block
// depends on lero_pkg, lero_line_buf and label_erosion_3x3_defines.svh
`timescale 1ns / 1ps
`include "label_erosion_3x3_defines.svh"

// channel | direction | handshake             | payload
// s_axis  | in        | tvalid / tready       | tdata: pixel_value, tuser: command
// m_axis  | out       | tvalid / tready       | tdata: out_pixel, tlast: frame_done
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per clock sustained while the output is not stalled; a result is held in the work stage
// for the registered read of the line store memory, then loaded into the output register
// reset clears counters, window and valids and sets the configuration registers to defaults;
// the line store memory is not cleared and needs no clearing pass
// a stalled output holds one result while a second item waits in the work stage;
// input ready drops only when both are full

module label_erosion_3x3 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lero_pkg::PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_value
    input  logic                            s_axis_tuser,   // [0] command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lero_pkg::PIX_W-1:0]      m_axis_tdata,   // [7:0] out_pixel
    output logic                            m_axis_tlast,   // frame_done
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lero_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lero_pkg::DIM_W-1:0]      cfg_data
);
    import lero_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [DIM_W-1:0] roi_col_start_reg, roi_col_end_reg;
    logic [DIM_W-1:0] roi_row_start_reg, roi_row_end_reg;
    logic [PIX_W-1:0] target_label_reg;
    logic             eight_connected_reg;

    // position counters
    logic [ADDR_W-1:0] col_cnt_reg, col_cnt_next;
    logic [DIM_W-1:0]  row_cnt_reg, row_cnt_next;

    // work stage
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    pos_info_t         s1_info_reg;

    // window and output register
    window_t           win_reg, win_next;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_last_reg;

    logic              in_acc, out_free, s1_adv;
    logic [PIX_W-1:0]  pix_in, eroded;
    logic [DIM_W-1:0]  wd, ht, cc, rcu, col_ext;
    logic [DIM_W:0]    rc_s;
    pos_info_t         info_next;
    lb_ctl_t           lb_ctl;
    lb_word_t          lb_rd, lb_wr;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= DIM_W'(640);
            frame_height_reg    <= DIM_W'(480);
            roi_col_start_reg   <= '0;
            roi_col_end_reg     <= DIM_W'(640);
            roi_row_start_reg   <= '0;
            roi_row_end_reg     <= DIM_W'(480);
            target_label_reg    <= PIX_W'(255);
            eight_connected_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:     frame_width_reg     <= cfg_data;
                REG_FRAME_HEIGHT:    frame_height_reg    <= cfg_data;
                REG_ROI_COL_START:   roi_col_start_reg   <= cfg_data;
                REG_ROI_COL_END:     roi_col_end_reg     <= cfg_data;
                REG_ROI_ROW_START:   roi_row_start_reg   <= cfg_data;
                REG_ROI_ROW_END:     roi_row_end_reg     <= cfg_data;
                REG_TARGET_LABEL:    target_label_reg    <= cfg_data[PIX_W-1:0];
                REG_EIGHT_CONNECTED: eight_connected_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // effective frame size, zero acts as one and large values saturate
    always_comb
    begin
        priority if (frame_width_reg == '0)
            wd = DIM_W'(1);
        else if (frame_width_reg > DIM_W'(MAX_WIDTH))
            wd = DIM_W'(MAX_WIDTH);
        else
            wd = frame_width_reg;
        priority if (frame_height_reg == '0)
            ht = DIM_W'(1);
        else if (frame_height_reg > DIM_W'(MAX_HEIGHT))
            ht = DIM_W'(MAX_HEIGHT);
        else
            ht = frame_height_reg;
    end

    // handshakes
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_adv        = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pix_in        = s_axis_tuser ? '0 : s_axis_tdata;

    // centre position of the window after this item, and border flags
    always_comb
    begin
        col_ext = DIM_W'(col_cnt_reg);
        if (col_cnt_reg != '0)
        begin
            rc_s = {1'b0, row_cnt_reg} - (DIM_W+1)'(1);
            cc   = col_ext - DIM_W'(1);
        end
        else
        begin
            rc_s = {1'b0, row_cnt_reg} - (DIM_W+1)'(2);
            cc   = wd - DIM_W'(1);
        end
        rcu = rc_s[DIM_W-1:0];
        info_next.emit   = !rc_s[DIM_W];
        info_next.done   = !rc_s[DIM_W] && (rcu == ht - DIM_W'(1)) && (cc == wd - DIM_W'(1));
        info_next.in_roi = (rcu >= roi_row_start_reg) && (rcu < roi_row_end_reg) &&
                           (cc >= roi_col_start_reg) && (cc < roi_col_end_reg);
        info_next.row_ok[0] = (rcu != '0) && (rcu <= ht);
        info_next.row_ok[1] = (rcu < ht);
        info_next.row_ok[2] = ({1'b0, rcu} + (DIM_W+1)'(1)) < {1'b0, ht};
        info_next.col_ok[0] = (cc != '0) && (cc <= wd);
        info_next.col_ok[1] = (cc < wd);
        info_next.col_ok[2] = ({1'b0, cc} + (DIM_W+1)'(1)) < {1'b0, wd};
    end

    // next counter values
    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        priority if (info_next.done)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (col_ext >= wd - DIM_W'(1))
        begin
            col_cnt_next = '0;
            if ({1'b0, row_cnt_reg} >= ({1'b0, ht} + (DIM_W+1)'(1)))
                row_cnt_next = '0;
            else
                row_cnt_next = row_cnt_reg + DIM_W'(1);
        end
        else
        begin
            col_cnt_next = col_cnt_reg + ADDR_W'(1);
        end
    end

    // counters and work stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                col_cnt_reg <= col_cnt_next;
                row_cnt_reg <= row_cnt_next;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg  <= pix_in;
            s1_addr_reg <= col_cnt_reg;
            s1_info_reg <= info_next;
        end
    end

    // line store: read when an item is taken, written back as it leaves the work stage
    assign lb_ctl.rd_en   = in_acc;
    assign lb_ctl.rd_addr = col_cnt_reg;
    assign lb_ctl.wr_en   = s1_adv;
    assign lb_ctl.wr_addr = s1_addr_reg;
    assign lb_wr          = {lb_rd[PIX_W-1:0], s1_pix_reg};

    lero_line_buf u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lb_ctl),
        .wr_data (lb_wr),
        .rd_data (lb_rd)
    );

    // window shift and erosion
    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = lb_rd[2*PIX_W-1:PIX_W];
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = lb_rd[PIX_W-1:0];
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_pix_reg;
        eroded = erode_px(win_next, target_label_reg, eight_connected_reg, s1_info_reg);
    end

    // window and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                win_reg <= win_next;
            if (s1_adv)
                out_valid_reg <= s1_info_reg.emit;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_info_reg.emit)
        begin
            out_pixel_reg <= eroded;
            out_last_reg  <= s1_info_reg.done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

    `LERO_ASSERT(a_stall_only_when_full, !s_axis_tready |-> s1_valid_reg && out_valid_reg,
        "input stalled while work stage or output register free")
    `LERO_ASSERT_NEXT(a_emit_loads_output, s1_adv && s1_info_reg.emit, m_axis_tvalid,
        "emitting item did not reach the output register")
    `LERO_ASSERT_NEXT(a_frame_end_restart, in_acc && info_next.done,
        col_cnt_reg == '0 && row_cnt_reg == '0, "counters not cleared after frame end")

endmodule
